// ===== design/rme_pkg.sv =====
// Shared types, constants and decode tables for the register machine executor.
package rme_pkg;

    // Default configuration of the machine
    localparam int NUM_REGS_DEF  = 6;
    localparam int WORD_BITS_DEF = 64;

    // Fixed field widths
    localparam int OPCODE_W   = 4;
    localparam int OPERAND_W  = 32;
    localparam int DEST_W     = 3;
    localparam int IP_W       = 32;
    localparam int WVAL_W     = 64;
    localparam int STATUS_W   = 2;
    localparam int BIND_W     = 3;
    localparam int PLEN_W     = 17;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // Reset values of the configuration registers
    localparam logic [BIND_W-1:0] IP_BINDING_RST     = 3'd6;
    localparam logic [PLEN_W-1:0] PROGRAM_LENGTH_RST = 17'd1;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_IP_BINDING     = 1'b0,
        CFG_PROGRAM_LENGTH = 1'b1
    } cfg_idx_t;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ADDR = 4'd0,
        OP_ADDI = 4'd1,
        OP_MULR = 4'd2,
        OP_MULI = 4'd3,
        OP_BANR = 4'd4,
        OP_BANI = 4'd5,
        OP_BORR = 4'd6,
        OP_BORI = 4'd7,
        OP_SETR = 4'd8,
        OP_SETI = 4'd9,
        OP_GTIR = 4'd10,
        OP_GTRI = 4'd11,
        OP_GTRR = 4'd12,
        OP_EQIR = 4'd13,
        OP_EQRI = 4'd14,
        OP_EQRR = 4'd15
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_RUNNING = 2'd0,
        ST_HALTED  = 2'd1,
        ST_BAD_OP  = 2'd2,
        ST_BAD_REG = 2'd3
    } status_t;

    // Bit n set: operand of opcode n names a register
    localparam logic [15:0] A_REG_MASK = 16'hD9FF;
    localparam logic [15:0] B_REG_MASK = 16'hB455;

    function automatic logic is_mul(input opcode_t op);
        return (op == OP_MULR) || (op == OP_MULI);
    endfunction

endpackage

// ===== design/rme_mul.sv =====
// Multiplier: registered 32x32 partial products, low word of the product.
module rme_mul #(
    parameter int WORD_BITS = rme_pkg::WORD_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 load,
    input  logic [WORD_BITS-1:0] a,
    input  logic [WORD_BITS-1:0] b,
    output logic [WORD_BITS-1:0] product
);
    import rme_pkg::*;

    logic [63:0] a_ext;
    logic [63:0] b_ext;
    logic [63:0] pp_lo_reg;
    logic [31:0] pp_hl_reg;
    logic [31:0] pp_lh_reg;
    logic [63:0] sum;
    logic [31:0] cross_sum;

    assign a_ext = 64'($signed(a));
    assign b_ext = 64'($signed(b));

    // Only the low 64 bits matter, so the high x high term drops out
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pp_lo_reg <= a_ext[31:0] * b_ext[31:0];
            pp_hl_reg <= 32'(a_ext[63:32] * b_ext[31:0]);
            pp_lh_reg <= 32'(a_ext[31:0] * b_ext[63:32]);
        end
    end

    assign cross_sum = pp_hl_reg + pp_lh_reg;
    assign sum       = pp_lo_reg + {cross_sum, 32'd0};
    assign product   = sum[WORD_BITS-1:0];

endmodule

// ===== design/rme_alu.sv =====
// Result selection for the sixteen opcodes.
module rme_alu #(
    parameter int WORD_BITS = rme_pkg::WORD_BITS_DEF
) (
    input  rme_pkg::opcode_t     op,
    input  logic [WORD_BITS-1:0] av,
    input  logic [WORD_BITS-1:0] bv,
    input  logic [WORD_BITS-1:0] product,
    output logic [WORD_BITS-1:0] res
);
    import rme_pkg::*;

    logic gt;
    logic eq;

    assign gt = $signed(av) > $signed(bv);
    assign eq = av == bv;

    always_comb
    begin
        case (op)
            OP_ADDR, OP_ADDI:          res = av + bv;
            OP_MULR, OP_MULI:          res = product;
            OP_BANR, OP_BANI:          res = av & bv;
            OP_BORR, OP_BORI:          res = av | bv;
            OP_SETR, OP_SETI:          res = av;
            OP_GTIR, OP_GTRI, OP_GTRR: res = WORD_BITS'(gt);
            OP_EQIR, OP_EQRI, OP_EQRR: res = WORD_BITS'(eq);
            default:                   res = '0;
        endcase
    end

endmodule

// ===== design/register_machine_instruction_executor.sv =====
// Top level of the register machine instruction executor.
// Executes one instruction per input transfer on NUM_REGS signed registers of WORD_BITS
// bits and returns one result transfer per instruction: the next fetch address, the value
// written and a status (running, halted, bad register index). An instruction goes into an
// input register and is executed from there against the register file, so results of
// one instruction feed the next with no gap. Add, logic, set and compare instructions
// execute in a single pass, so a new transfer is accepted every cycle while the result
// side does not stall; a multiply first loads the 32x32 partial-product multiplier,
// whose products are registered before they are summed, and then retires. The result
// passes through the input register and then the result register before it is
// presented. A result register parts the two sides, so a stalled output holds only the
// instruction behind it. The pointer is either a register of the file (ip_binding below
// NUM_REGS) or a separate counter. If the pointer is negative or at least program_length
// when an instruction arrives, nothing executes and halted is reported. The user
// must write configuration through the APB port only while the block is idle; the block
// does not enforce this. ip_binding is at address 0, program_length at address 4.
module register_machine_instruction_executor #(
    parameter int NUM_REGS  = rme_pkg::NUM_REGS_DEF,
    parameter int WORD_BITS = rme_pkg::WORD_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // APB configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rme_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [rme_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [rme_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    // instruction channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [rme_pkg::OPCODE_W-1:0]    opcode,
    input  logic [rme_pkg::OPERAND_W-1:0]   operand_a,
    input  logic [rme_pkg::OPERAND_W-1:0]   operand_b,
    input  logic [rme_pkg::DEST_W-1:0]      dest_index,
    // result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [rme_pkg::IP_W-1:0]        next_ip,
    output logic [rme_pkg::WVAL_W-1:0]      written_value,
    output logic [rme_pkg::STATUS_W-1:0]    status
);
    import rme_pkg::*;

    localparam int IDX_W = $clog2(NUM_REGS);

    // ---------------------------------------------------------------- config
    logic [BIND_W-1:0] ip_binding_reg;
    logic [PLEN_W-1:0] program_length_reg;
    logic              cfg_wr;
    cfg_idx_t          cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = cfg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ip_binding_reg     <= IP_BINDING_RST;
            program_length_reg <= PROGRAM_LENGTH_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                CFG_IP_BINDING:     ip_binding_reg     <= pwdata[BIND_W-1:0];
                CFG_PROGRAM_LENGTH: program_length_reg <= pwdata[PLEN_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            CFG_IP_BINDING:     prdata = APB_DATA_W'(ip_binding_reg);
            CFG_PROGRAM_LENGTH: prdata = APB_DATA_W'(program_length_reg);
            default:            prdata = '0;
        endcase
    end

    // ---------------------------------------------------------- input stage
    logic                 in_valid_reg;
    opcode_t              in_op_reg;
    logic [OPERAND_W-1:0] in_a_reg;
    logic [OPERAND_W-1:0] in_b_reg;
    logic [DEST_W-1:0]    in_dest_reg;
    logic                 in_xfer;
    logic                 advance;
    logic                 mul_wait;
    logic                 mul_done_reg;
    logic                 mul_done_next;

    assign in_xfer  = in_valid && !in_stall;
    assign mul_wait = is_mul(in_op_reg) && !mul_done_reg;
    assign advance  = in_valid_reg && !mul_wait && (!out_valid || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_op_reg   <= opcode_t'(opcode);
            in_a_reg    <= operand_a;
            in_b_reg    <= operand_b;
            in_dest_reg <= dest_index;
        end
    end

    // a multiply first loads the partial products, then retires
    always_comb
    begin
        mul_done_next = mul_done_reg;
        if (advance)
            mul_done_next = 1'b0;
        else if (in_valid_reg && mul_wait)
            mul_done_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_done_reg <= 1'b0;
        else
            mul_done_reg <= mul_done_next;
    end

    // -------------------------------------------------------- machine state
    logic [WORD_BITS-1:0] rf_reg [NUM_REGS];
    logic [WORD_BITS-1:0] ptr_cnt_reg;

    logic                 bound;
    logic [IDX_W-1:0]     bind_idx;
    logic [WORD_BITS-1:0] ptr;
    logic                 ptr_out;

    assign bound    = 32'(ip_binding_reg) < 32'(NUM_REGS);
    assign bind_idx = IDX_W'(ip_binding_reg);
    assign ptr      = bound ? rf_reg[bind_idx] : ptr_cnt_reg;
    assign ptr_out  = ptr[WORD_BITS-1] || (64'(ptr) >= 64'(program_length_reg));

    // ------------------------------------------------------ operand decode
    logic                 a_is_reg;
    logic                 b_is_reg;
    logic                 bad_reg;
    logic [IDX_W-1:0]     a_idx;
    logic [IDX_W-1:0]     b_idx;
    logic [IDX_W-1:0]     d_idx;
    logic [WORD_BITS-1:0] av;
    logic [WORD_BITS-1:0] bv;
    logic [WORD_BITS-1:0] product;
    logic [WORD_BITS-1:0] res;

    assign a_is_reg = A_REG_MASK[in_op_reg];
    assign b_is_reg = B_REG_MASK[in_op_reg];
    assign bad_reg  = (a_is_reg && (in_a_reg >= 32'(NUM_REGS)))
                   || (b_is_reg && (in_b_reg >= 32'(NUM_REGS)))
                   || (32'(in_dest_reg) >= 32'(NUM_REGS));
    assign a_idx    = in_a_reg[IDX_W-1:0];
    assign b_idx    = in_b_reg[IDX_W-1:0];
    assign d_idx    = IDX_W'(in_dest_reg);

    // immediates are sign-extended from 32 bits, then cut to the word
    assign av = a_is_reg ? rf_reg[a_idx] : WORD_BITS'($signed(in_a_reg));
    assign bv = b_is_reg ? rf_reg[b_idx] : WORD_BITS'($signed(in_b_reg));

    rme_mul #(
        .WORD_BITS (WORD_BITS)
    ) u_mul (
        .clk     (clk),
        .load    (in_valid_reg && mul_wait),
        .a       (av),
        .b       (bv),
        .product (product)
    );

    rme_alu #(
        .WORD_BITS (WORD_BITS)
    ) u_alu (
        .op      (in_op_reg),
        .av      (av),
        .bv      (bv),
        .product (product),
        .res     (res)
    );

    // ------------------------------------------------------ pointer update
    logic                 exec;
    logic                 dest_is_ptr;
    logic [WORD_BITS-1:0] ptr_base;
    logic [WORD_BITS-1:0] ptr_inc;
    logic                 end_hit;
    logic [WORD_BITS-1:0] np;
    status_t              st;
    logic [WORD_BITS-1:0] ip_report;
    logic [WORD_BITS-1:0] wval;

    assign exec = !ptr_out && !bad_reg;

    // writing the bound pointer register makes the written value the new base
    assign dest_is_ptr = bound && (d_idx == bind_idx);
    assign ptr_base    = dest_is_ptr ? res : ptr;
    assign ptr_inc     = ptr_base + WORD_BITS'(1);
    assign end_hit     = !ptr_inc[WORD_BITS-1]
                      && (64'(ptr_inc) >= 64'(program_length_reg));
    assign np          = end_hit ? ptr_base : ptr_inc;

    always_comb
    begin
        if (ptr_out)
        begin
            st        = ST_HALTED;
            ip_report = ptr;
            wval      = '0;
        end
        else if (bad_reg)
        begin
            st        = ST_BAD_REG;
            ip_report = ptr;
            wval      = '0;
        end
        else
        begin
            st        = end_hit ? ST_HALTED : ST_RUNNING;
            ip_report = np;
            wval      = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
                rf_reg[i] <= '0;
            ptr_cnt_reg <= '0;
        end
        else if (advance && exec)
        begin
            // np already carries the result when dest is the bound register
            if (!dest_is_ptr)
                rf_reg[d_idx] <= res;
            if (bound)
                rf_reg[bind_idx] <= np;
            else
                ptr_cnt_reg <= np;
        end
    end

    // --------------------------------------------------------- result stage
    logic                 out_valid_reg;
    logic [IP_W-1:0]      next_ip_reg;
    logic [WVAL_W-1:0]    written_value_reg;
    logic [STATUS_W-1:0]  status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            next_ip_reg       <= IP_W'($signed(ip_report));
            written_value_reg <= WVAL_W'($signed(wval));
            status_reg        <= st;
        end
    end

    assign out_valid     = out_valid_reg;
    assign next_ip       = next_ip_reg;
    assign written_value = written_value_reg;
    assign status        = status_reg;

endmodule

// ===== test/register_machine_instruction_executor_test.sv =====
// Self-checking testbench for the register machine instruction executor.
`timescale 1ns / 1ps

import rme_pkg::*;

localparam int NREGS = rme_pkg::NUM_REGS_DEF;

// Operand decode: which operands name a register rather than an immediate
function automatic bit reads_reg_a(input opcode_t op);
    case (op)
        OP_SETI, OP_GTIR, OP_EQIR: return 1'b0;
        default:                   return 1'b1;
    endcase
endfunction

function automatic bit reads_reg_b(input opcode_t op);
    case (op)
        OP_ADDR, OP_MULR, OP_BANR, OP_BORR,
        OP_GTIR, OP_GTRR, OP_EQIR, OP_EQRR: return 1'b1;
        default:                            return 1'b0;
    endcase
endfunction

// Machine state mirror plus the queue of results still owed by the block
class exec_scoreboard;
    typedef struct {
        logic [IP_W-1:0]   ip;
        logic [WVAL_W-1:0] wv;
        status_t           st;
    } step_result_t;

    step_result_t     owed_q[$];
    logic [63:0]      regs[NREGS];
    logic [63:0]      ptr_cnt;
    logic [BIND_W-1:0] ptr_sel;
    logic [PLEN_W-1:0] plen;
    int               errors;

    function new();
        foreach (regs[i]) regs[i] = '0;
        ptr_cnt = '0;
        ptr_sel = IP_BINDING_RST;
        plen    = PROGRAM_LENGTH_RST;
        errors  = 0;
    endfunction

    function void set_config(input cfg_idx_t idx, input logic [31:0] val);
        if (idx == CFG_IP_BINDING) ptr_sel = val[BIND_W-1:0];
        else                       plen    = val[PLEN_W-1:0];
    endfunction

    function int outstanding();
        return owed_q.size();
    endfunction

    function void note_instr(input opcode_t op, input logic [31:0] a, input logic [31:0] b,
                             input logic [DEST_W-1:0] d);
        logic [63:0]  ptr;
        logic [63:0]  av;
        logic [63:0]  bv;
        logic [63:0]  res;
        logic [63:0]  np;
        bit           on_reg;
        step_result_t r;
        on_reg = (ptr_sel < NREGS);
        ptr    = on_reg ? regs[ptr_sel] : ptr_cnt;
        r.ip   = ptr[IP_W-1:0];
        r.wv   = '0;
        if (ptr[63] || ptr >= 64'(plen)) begin
            r.st = ST_HALTED;
        end else if ((reads_reg_a(op) && a >= 32'(NREGS)) ||
                     (reads_reg_b(op) && b >= 32'(NREGS)) || d >= NREGS) begin
            r.st = ST_BAD_REG;
        end else begin
            av = reads_reg_a(op) ? regs[a[2:0]] : {{32{a[31]}}, a};
            bv = reads_reg_b(op) ? regs[b[2:0]] : {{32{b[31]}}, b};
            case (op)
                OP_ADDR, OP_ADDI:          res = av + bv;
                OP_MULR, OP_MULI:          res = av * bv;
                OP_BANR, OP_BANI:          res = av & bv;
                OP_BORR, OP_BORI:          res = av | bv;
                OP_SETR, OP_SETI:          res = av;
                OP_GTIR, OP_GTRI, OP_GTRR: res = ($signed(av) > $signed(bv)) ? 64'd1 : 64'd0;
                default:                   res = (av == bv) ? 64'd1 : 64'd0;
            endcase
            regs[d] = res;
            // pointer re-read: a write to the bound register is what gets incremented
            ptr  = on_reg ? regs[ptr_sel] : ptr_cnt;
            np   = ptr + 64'd1;
            r.st = ST_RUNNING;
            if (!np[63] && np >= 64'(plen)) begin
                np   = np - 64'd1;
                r.st = ST_HALTED;
            end
            if (on_reg) regs[ptr_sel] = np;
            else        ptr_cnt       = np;
            r.ip = np[IP_W-1:0];
            r.wv = res;
        end
        owed_q.push_back(r);
    endfunction

    function void check_result(input logic [IP_W-1:0] ip, input logic [WVAL_W-1:0] wv,
                               input logic [STATUS_W-1:0] st);
        step_result_t r;
        if (owed_q.size() == 0) begin
            $display("%0t: result with none owed: next_ip %h, value %h, status %0d",
                     $time, ip, wv, st);
            errors++;
            return;
        end
        r = owed_q.pop_front();
        if (ip !== r.ip) begin
            $display("%0t: next_ip expected %h, actual %h", $time, r.ip, ip);
            errors++;
        end
        if (wv !== r.wv) begin
            $display("%0t: written_value expected %h, actual %h", $time, r.wv, wv);
            errors++;
        end
        if (st !== r.st) begin
            $display("%0t: status expected %0d, actual %0d", $time, r.st, st);
            errors++;
        end
    endfunction
endclass

module register_machine_instruction_executor_test;

    // ip_binding value that selects the stand-alone pointer counter
    localparam logic [BIND_W-1:0] SEL_COUNTER = 3'd6;
    localparam logic [BIND_W-1:0] SEL_COUNTER_ALT = 3'd7;
    localparam logic [PLEN_W-1:0] PLEN_MAX = 17'd65536;
    // settling time past the last result before touching configuration
    localparam int SETTLE_CYCLES = 6;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD = 300;

    logic                    clk;
    logic                    rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [APB_ADDR_W-1:0]   paddr;
    logic [APB_DATA_W-1:0]   pwdata;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;
    logic                    in_valid;
    logic                    in_stall;
    logic [OPCODE_W-1:0]     opcode;
    logic [OPERAND_W-1:0]    operand_a;
    logic [OPERAND_W-1:0]    operand_b;
    logic [DEST_W-1:0]       dest_index;
    logic                    out_valid;
    logic                    out_stall;
    logic [IP_W-1:0]         next_ip;
    logic [WVAL_W-1:0]       written_value;
    logic [STATUS_W-1:0]     status;

    exec_scoreboard book = new();

    // calm: no idling on either side; hold_request: ask the result side for a long stall
    bit calm = 1'b0;
    int hold_request = 0;
    int cycles = 0;

    register_machine_instruction_executor uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .operand_a    (operand_a),
        .operand_b    (operand_b),
        .dest_index   (dest_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .next_ip      (next_ip),
        .written_value(written_value),
        .status       (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: the slowest correct run is far below this
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("register_machine_instruction_executor test failed");
        $finish;
    end

    // Result side: check every transfer, then pick the stall for the next cycle.
    // A requested hold is counted down here, independent of the instruction side.
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                book.check_result(next_ip, written_value, status);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !calm && ($urandom_range(99) < 33);
        end
    end

    // APB write: setup cycle, then access until pready, then an idle wait so the
    // next write never drives psel twice in one step
    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        book.set_config(idx, val);
        @(posedge clk);
    endtask

    // One instruction transfer. Valid stays up after acceptance; the next call either
    // drops it for idle cycles or replaces the payload, never both in one step.
    task automatic send_instr(input opcode_t op, input logic [31:0] a, input logic [31:0] b,
                              input logic [DEST_W-1:0] d);
        while (!calm && $urandom_range(99) < 33)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        operand_a  <= a;
        operand_b  <= b;
        dest_index <= d;
        do @(posedge clk); while (in_stall);
        book.note_instr(op, a, b, d);
    endtask

    // Drain: stop offering, wait for every owed result, then let the pipe go quiet
    task automatic settle();
        in_valid <= 1'b0;
        while (book.outstanding() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_reg_operand();
        case ($urandom_range(24))
            0:       return 32'(NREGS + $urandom_range(1));  // just past the file
            1:       return $urandom;                        // huge or negative index
            default: return 32'($urandom_range(NREGS - 1));
        endcase
    endfunction

    function automatic logic [31:0] pick_immediate();
        case ($urandom_range(9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3, 4, 5: return $urandom;
            default: return 32'($urandom_range(20)) - 32'd4;
        endcase
    endfunction

    // Random instruction. While the pointer lives in a register, writes to that
    // register become jumps inside the program so execution keeps going.
    task automatic send_random(input logic [BIND_W-1:0] sel, input logic [PLEN_W-1:0] len);
        opcode_t             op;
        logic [31:0]         a;
        logic [31:0]         b;
        logic [DEST_W-1:0]   d;
        op = opcode_t'($urandom_range(15));
        a  = reads_reg_a(op) ? pick_reg_operand() : pick_immediate();
        b  = reads_reg_b(op) ? pick_reg_operand() : pick_immediate();
        if ($urandom_range(19) == 0)
            d = DEST_W'(NREGS + $urandom_range(1));
        else
            d = DEST_W'($urandom_range(NREGS - 1));
        if (sel < NREGS && d == sel)
        begin
            op = OP_SETI;
            a  = 32'($urandom_range(int'(len) - 1));
        end
        send_instr(op, a, b, d);
    endtask

    // Select the pointer and program length. A register pointer first gets a start
    // address of zero, written while the counter (always in range at full length) runs.
    task automatic set_machine(input logic [BIND_W-1:0] sel, input logic [PLEN_W-1:0] len);
        if (sel < NREGS)
        begin
            write_reg(CFG_IP_BINDING, 32'(SEL_COUNTER));
            write_reg(CFG_PROGRAM_LENGTH, 32'(PLEN_MAX));
            send_instr(OP_SETI, 32'd0, $urandom, sel);
            settle();
        end
        write_reg(CFG_IP_BINDING, 32'(sel));
        write_reg(CFG_PROGRAM_LENGTH, 32'(len));
    endtask

    task automatic run_phase(input logic [BIND_W-1:0] sel, input logic [PLEN_W-1:0] len,
                             input int count);
        set_machine(sel, len);
        repeat (count) send_random(sel, len);
        settle();
    endtask

    initial
    begin
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        in_valid   = 1'b0;
        opcode     = '0;
        operand_a  = '0;
        operand_b  = '0;
        dest_index = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at reset configuration: counter pointer, length one, so each
        // instruction executes and reports halted with the pointer back at zero.
        send_instr(OP_SETI, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 3'd0);  // operand b ignored
        send_instr(OP_SETI, 32'h8000_0000, 32'd0, 3'd1);
        send_instr(OP_MULR, 32'd0, 32'd0, 3'd2);
        send_instr(OP_MULR, 32'd2, 32'd2, 3'd3);                  // wraps
        send_instr(OP_ADDR, 32'd0, 32'd1, 3'd4);
        send_instr(OP_ADDI, 32'd4, 32'hFFFF_FFFF, 3'd5);
        send_instr(OP_MULI, 32'd1, 32'h8000_0000, 3'd0);
        send_instr(OP_BANR, 32'd0, 32'd3, 3'd1);
        send_instr(OP_BANI, 32'd3, 32'h0F0F_0F0F, 3'd2);
        send_instr(OP_BORR, 32'd1, 32'd2, 3'd3);
        send_instr(OP_BORI, 32'd4, 32'h8000_0000, 3'd4);
        send_instr(OP_SETR, 32'd5, 32'hDEAD_BEEF, 3'd5);          // bad b never checked
        send_instr(OP_GTIR, 32'hFFFF_FFFF, 32'd1, 3'd0);          // signed compare
        send_instr(OP_GTRI, 32'd1, 32'h7FFF_FFFF, 3'd1);
        send_instr(OP_GTRR, 32'd2, 32'd3, 3'd2);
        send_instr(OP_EQIR, 32'd0, 32'd4, 3'd3);
        send_instr(OP_EQRI, 32'd5, 32'hFFFF_FFFF, 3'd4);
        send_instr(OP_EQRR, 32'd0, 32'd0, 3'd5);
        // bad register index: operand past the file, negative operand, bad destination
        send_instr(OP_ADDR, 32'd6, 32'd0, 3'd0);
        send_instr(OP_ADDR, 32'd0, 32'hFFFF_FFFF, 3'd1);
        send_instr(OP_SETR, 32'h8000_0000, 32'd0, 3'd2);
        send_instr(OP_GTIR, 32'd100, 32'd7, 3'd3);
        send_instr(OP_SETI, 32'd5, 32'd0, 3'd6);
        send_instr(OP_ADDI, 32'd0, 32'd1, 3'd7);
        settle();

        // Counter at full length; the result side holds off for a long stretch so the
        // block backs up and stalls its input while new instructions keep coming.
        hold_request = LONG_HOLD;
        run_phase(SEL_COUNTER, PLEN_MAX, 250);
        // Short program: the counter is likely already past the end, so all halt
        run_phase(SEL_COUNTER, 17'd40, 30);
        run_phase(3'd2, 17'd64, 250);
        // A stretch with no idling on either side
        calm = 1'b1;
        run_phase(3'd0, PLEN_MAX, 250);
        calm = 1'b0;
        run_phase(SEL_COUNTER_ALT, 17'd65535, 150);
        run_phase(3'd5, 17'd3, 100);
        // Zero length: every instruction halts
        run_phase(SEL_COUNTER, 17'd0, 20);

        // Jump to a negative address: the step runs, then everything after halts
        set_machine(3'd1, PLEN_MAX);
        send_instr(OP_SETI, 32'hFFFF_FFFD, 32'd0, 3'd1);
        repeat (5) send_random(3'd1, PLEN_MAX);
        settle();

        if (book.errors == 0)
            $display("register_machine_instruction_executor test passed");
        else
            $display("register_machine_instruction_executor test failed");
        $finish;
    end

endmodule
